/* sv/fht_pkg.sv */
// Shared types and constants of the frequency hop table.
package fht_pkg;

    // Beat field widths
    localparam int KIND_W      = 3;
    localparam int FREQ_W      = 32;
    localparam int SLOT_W      = 8;
    localparam int STORE_W     = 30;
    localparam int ADDED_W     = 5;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 48;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request kind codes as they arrive on tuser
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CURSOR = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

    // Accepted bands, bounds included
    localparam int BAND_COUNT = 3;
    localparam logic [FREQ_W-1:0] BAND_LO [BAND_COUNT] =
        '{32'd300000000, 32'd387000000, 32'd779000000};
    localparam logic [FREQ_W-1:0] BAND_HI [BAND_COUNT] =
        '{32'd348000000, 32'd464000000, 32'd928000000};

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_ADD,
        OP_RANGE,
        OP_HOP,
        OP_CURSOR,
        OP_READ,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [FREQ_W-1:0] freq;
        logic [FREQ_W-1:0] range_end;
        logic [FREQ_W-1:0] range_step;
        logic [SLOT_W-1:0] slot;
        logic              in_band;
        logic              reject;
    } cmd_t;

    typedef struct packed {
        logic                   ok;
        logic [ADDED_W-1:0]     added;
        logic [STORE_W-1:0]     freq_out;
        logic [SLOT_OUT_W-1:0]  slot_out;
        logic [COUNT_OUT_W-1:0] entry_count;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_BAND,
        ST_DIV,
        ST_WALK,
        ST_RESP
    } state_t;

endpackage

/* sv/fht_front.sv */
// Front end: unpacks an input beat and classifies it into a command.
module fht_front
    import fht_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 push_valid,
    input  logic                 push_ready,
    output cmd_t                 push_cmd
);

    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] range_end;
    logic [FREQ_W-1:0] range_step;
    logic              in_band;

    assign freq       = s_tdata[31:0];
    assign range_end  = s_tdata[63:32];
    assign range_step = s_tdata[95:64];

    always_comb begin
        in_band = 1'b0;
        for (int b = 0; b < BAND_COUNT; b++) begin
            if (freq >= BAND_LO[b] && freq <= BAND_HI[b]) begin
                in_band = 1'b1;
            end
        end
    end

    always_comb begin
        push_cmd.freq       = freq;
        push_cmd.range_end  = range_end;
        push_cmd.range_step = range_step;
        push_cmd.slot       = s_tdata[103:96];
        push_cmd.in_band    = in_band;
        push_cmd.reject     = (range_step == '0) || (range_end < freq);
        case (s_tuser)
            KIND_CLEAR:  push_cmd.op = OP_CLEAR;
            KIND_ADD:    push_cmd.op = OP_ADD;
            KIND_RANGE:  push_cmd.op = OP_RANGE;
            KIND_HOP:    push_cmd.op = OP_HOP;
            KIND_CURSOR: push_cmd.op = OP_CURSOR;
            KIND_READ:   push_cmd.op = OP_READ;
            default:     push_cmd.op = OP_IGNORE;
        endcase
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

/* sv/fht_queue.sv */
// Short command queue between front and back.
module fht_queue
    import fht_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           entries_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;
    logic           push, pop;

    assign in_ready  = (fill_reg != QCW'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        fill_next = fill_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* sv/fht_rem.sv */
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module fht_rem
    import fht_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [FREQ_W-1:0] dividend,
    input  logic [FREQ_W-1:0] divisor,
    output logic              done,
    output logic [FREQ_W-1:0] remainder
);

    localparam int CNT_W = $clog2(FREQ_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] dvd_reg, dvd_next;
    logic [FREQ_W-1:0] dsr_reg, dsr_next;
    logic [FREQ_W:0]   shifted;
    logic [FREQ_W:0]   diff;

    // partial remainder stays below the divisor, so it fits FREQ_W bits
    assign shifted   = {rem_reg, dvd_reg[FREQ_W-1]};
    assign diff      = shifted - {1'b0, dsr_reg};
    assign done      = done_reg;
    assign remainder = rem_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = (shifted >= {1'b0, dsr_reg}) ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
            dvd_next = {dvd_reg[FREQ_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(FREQ_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

endmodule

/* sv/fht_back.sv */
// Back end: executes commands against the table and drives the result register.
module fht_back
    import fht_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  cmd_t q_cmd,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = $clog2(BAND_COUNT);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     cursor_reg, cursor_next;
    logic [BW-1:0]     band_reg, band_next;
    logic [FREQ_W-1:0] lim_reg, lim_next;
    logic [FREQ_W:0]   f_reg, f_next;
    logic              ok_reg, ok_next;
    logic [CW-1:0]     added_reg, added_next;
    logic [STORE_W-1:0] fout_reg, fout_next;
    logic [AW-1:0]     sout_reg, sout_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg, m_res_next;

    // table memory
    logic [STORE_W-1:0] mem [MAX_ENTRIES];
    logic [STORE_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [STORE_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;

    // remainder unit
    logic              rem_start;
    logic              rem_done;
    logic [FREQ_W-1:0] rem_val;

    // shared decode
    logic              full;
    logic              out_free;
    logic [FREQ_W-1:0] lo, hi, lim_c;
    logic              band_skip, band_last;
    logic              slot_ok;
    logic [AW-1:0]     hop_c;
    logic [CW-1:0]     hop_plus;
    logic              walk_go;

    assign full      = (count_reg == CW'(MAX_ENTRIES));
    assign out_free  = !m_valid_reg || m_ready;
    assign lo        = BAND_LO[band_reg];
    assign hi        = BAND_HI[band_reg];
    assign lim_c     = (hi < cmd_reg.range_end) ? hi : cmd_reg.range_end;
    assign band_skip = full || (cmd_reg.freq > lim_c) || (lo > lim_c);
    assign band_last = (band_reg == BW'(BAND_COUNT - 1));
    assign slot_ok   = (32'(cmd_reg.slot) < 32'(count_reg));
    assign hop_c     = (32'(cursor_reg) < 32'(count_reg)) ? cursor_reg : '0;
    assign hop_plus  = CW'(hop_c) + CW'(1);
    assign walk_go   = (f_reg <= {1'b0, lim_reg}) && !full;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    fht_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (lo - cmd_reg.freq),
        .divisor   (cmd_reg.range_step),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                case (cmd_reg.op)
                    OP_RANGE: state_next = cmd_reg.reject ? ST_RESP : ST_BAND;
                    OP_HOP:   state_next = (count_reg == '0) ? ST_RESP : ST_READ;
                    OP_READ:  state_next = slot_ok ? ST_READ : ST_RESP;
                    default:  state_next = ST_RESP;
                endcase
            end
            ST_READ: state_next = ST_RESP;
            ST_BAND: begin
                if (band_skip) begin
                    state_next = band_last ? ST_RESP : ST_BAND;
                end else if (cmd_reg.freq >= lo) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_done) state_next = ST_WALK;
            end
            ST_WALK: begin
                if (!walk_go) state_next = band_last ? ST_RESP : ST_BAND;
            end
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        band_next    = band_reg;
        lim_next     = lim_reg;
        f_next       = f_reg;
        ok_next      = ok_reg;
        added_next   = added_reg;
        fout_next    = fout_reg;
        sout_next    = sout_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_res_next   = m_res_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = f_reg[STORE_W-1:0];
        rd_addr      = '0;
        rem_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd_next   = q_cmd;
                ok_next    = 1'b0;
                added_next = '0;
                fout_next  = '0;
                sout_next  = '0;
                band_next  = '0;
            end
            ST_EXEC: begin
                case (cmd_reg.op)
                    OP_CLEAR: begin
                        count_next  = '0;
                        cursor_next = '0;
                        ok_next     = 1'b1;
                    end
                    OP_ADD: begin
                        if (cmd_reg.in_band && !full) begin
                            wr_en      = 1'b1;
                            wr_data    = cmd_reg.freq[STORE_W-1:0];
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                            added_next = CW'(1);
                        end
                    end
                    OP_HOP: begin
                        if (count_reg != '0) begin
                            rd_addr     = hop_c;
                            sout_next   = hop_c;
                            cursor_next = (hop_plus == count_reg) ? '0 : hop_plus[AW-1:0];
                        end
                    end
                    OP_CURSOR: begin
                        cursor_next = '0;
                        ok_next     = 1'b1;
                    end
                    OP_READ: begin
                        if (slot_ok) begin
                            rd_addr   = cmd_reg.slot[AW-1:0];
                            sout_next = cmd_reg.slot[AW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            ST_READ: begin
                fout_next = rd_data_reg;
                ok_next   = 1'b1;
            end
            ST_BAND: begin
                lim_next = lim_c;
                if (band_skip) begin
                    if (!band_last) band_next = band_reg + BW'(1);
                end else if (cmd_reg.freq >= lo) begin
                    f_next = {1'b0, cmd_reg.freq};
                end else begin
                    rem_start = 1'b1;
                end
            end
            ST_DIV: begin
                // first candidate at or above the band floor
                if (rem_done) begin
                    f_next = (rem_val == '0) ? {1'b0, lo}
                           : {1'b0, lo} + {1'b0, cmd_reg.range_step} - {1'b0, rem_val};
                end
            end
            ST_WALK: begin
                if (walk_go) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    added_next = added_reg + CW'(1);
                    ok_next    = 1'b1;
                    f_next     = f_reg + {1'b0, cmd_reg.range_step};
                end else if (!band_last) begin
                    band_next = band_reg + BW'(1);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_res_next.ok          = ok_reg;
                    m_res_next.added       = ADDED_W'(added_reg);
                    m_res_next.freq_out    = fout_reg;
                    m_res_next.slot_out    = SLOT_OUT_W'(sout_reg);
                    m_res_next.entry_count = COUNT_OUT_W'(count_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            band_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            band_reg    <= band_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        lim_reg   <= lim_next;
        f_reg     <= f_next;
        ok_reg    <= ok_next;
        added_reg <= added_next;
        fout_reg  <= fout_next;
        sout_reg  <= sout_next;
        m_res_reg <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

/* sv/validated_frequency_hop_table.sv */
// Top level of the validated frequency hop table.
//
// Keeps up to MAX_ENTRIES radio frequencies and hands them out round-robin.
// A request beat carries its kind on s_tuser (clear, add, add range, hop next,
// reset cursor, read entry); every request yields exactly one result beat.
// Adds are taken only for frequencies inside 300-348 MHz, 387-464 MHz or
// 779-928 MHz (bounds included) while the table has room. A range request
// adds start, start+step, ... up to the range end, band by band, until the
// table fills. A front stage classifies requests into a two-deep command
// queue, so up to two further requests are taken while one executes and its
// result waits on m_tready. In the back end every request passes through an
// execute state and a response state; a hop or read that returns an entry
// adds one registered table read. A range request that is not rejected also
// visits, for each of the three bands, a setup state and, unless the band is
// skipped (table full, or no candidate inside it), runs the serial remainder
// unit when the range starts below that band and then walks one step per
// entry added plus a final step. Table contents are not cleared by reset or
// by a clear request; only the entry count and the hop cursor are.
module validated_frequency_hop_table
    import fht_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] frequency, [63:32] range_end, [95:64] range_step, [103:96] slot
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] kind
    input  logic [KIND_W-1:0]    s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] ok, [5:1] added, [35:6] freq_out, [39:36] slot_out,
    // [44:40] entry_count, [47:45] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    fht_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    fht_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    fht_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    // result beat packing, lowest field first
    assign m_tdata = {3'b000, res.entry_count, res.slot_out, res.freq_out,
                      res.added, res.ok};

endmodule
